// ===== src/eeg_pkg.sv =====
package eeg_pkg;

    // default word width; operands use one bit less
    localparam int DATA_WIDTH_DEF = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new item into the remainder and coefficient registers
        logic div_init;  // start a quotient step: clear partial remainder and products
        logic div_step;  // one restoring-division bit with shift-add of q*s and q*t
        logic update;    // rotate the remainder and coefficient pairs
        logic publish;   // copy the finished result into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic rc_zero;   // current remainder is zero, loop is done
    } t_dp_stat;

endpackage

// ===== src/eeg_dp.sv =====
module eeg_dp #(
    parameter int DATA_WIDTH = eeg_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic [DATA_WIDTH-2:0]        i_operand_a,
    input  logic [DATA_WIDTH-2:0]        i_operand_b,
    input  eeg_pkg::t_dp_cmd             i_cmd,
    output eeg_pkg::t_dp_stat            o_stat,
    output logic [DATA_WIDTH-2:0]        o_gcd_value,
    output logic signed [DATA_WIDTH-1:0] o_coeff_s,
    output logic signed [DATA_WIDTH-1:0] o_coeff_t
);

    localparam int OW = DATA_WIDTH - 1;
    localparam int CW = DATA_WIDTH;

    // remainder pair and coefficient pairs
    logic [OW-1:0] r_rp, r_rc;
    logic [CW-1:0] r_sp, r_sc, r_tp, r_tc;
    // division state: partial remainder, dividend shift register, running products
    logic [OW-1:0] r_rem, r_dq;
    logic [CW-1:0] r_ps, r_pt;
    // output register
    logic [OW-1:0] r_og;
    logic [CW-1:0] r_os, r_ot;

    logic [OW:0]   n_shift;
    logic          n_ge;
    logic [OW:0]   n_diff;
    logic [CW-1:0] n_ps, n_pt;

    // one restoring-division bit; quotient bit feeds the horner products
    always_comb begin
        n_shift = {r_rem, r_dq[OW-1]};
        n_diff  = n_shift - {1'b0, r_rc};
        n_ge    = (n_shift >= {1'b0, r_rc});
        n_ps    = {r_ps[CW-2:0], 1'b0} + (n_ge ? r_sc : '0);
        n_pt    = {r_pt[CW-2:0], 1'b0} + (n_ge ? r_tc : '0);
    end

    // remainder and coefficient registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rp <= i_operand_a;
            r_rc <= i_operand_b;
            r_sp <= CW'(1);
            r_sc <= '0;
            r_tp <= '0;
            r_tc <= CW'(1);
        end else if (i_cmd.update) begin
            r_rp <= r_rc;
            r_rc <= r_rem;
            r_sp <= r_sc;
            r_sc <= r_sp - r_ps;
            r_tp <= r_tc;
            r_tc <= r_tp - r_pt;
        end
    end

    // division registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_dq  <= r_rp;
            r_ps  <= '0;
            r_pt  <= '0;
        end else if (i_cmd.div_step) begin
            if (n_ge) begin
                r_rem <= n_diff[OW-1:0];
            end else begin
                r_rem <= n_shift[OW-1:0];
            end
            r_dq <= {r_dq[OW-2:0], 1'b0};
            r_ps <= n_ps;
            r_pt <= n_pt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_og <= r_rp;
            r_os <= r_sp;
            r_ot <= r_tp;
        end
    end

    assign o_stat.rc_zero = (r_rc == '0);
    assign o_gcd_value    = r_og;
    assign o_coeff_s      = r_os;
    assign o_coeff_t      = r_ot;

endmodule

// ===== src/eeg_ctrl.sv =====
module eeg_ctrl #(
    parameter int DATA_WIDTH = eeg_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output eeg_pkg::t_dp_cmd  o_cmd,
    input  eeg_pkg::t_dp_stat i_stat
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPD,
        ST_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_in_ready;
    logic               r_out_valid;
    logic               n_last_bit;

    assign n_last_bit = (r_cnt == CNT_W'(DATA_WIDTH - 2));

    // command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.rc_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (n_last_bit) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_CHECK;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, bit counter and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.div_init) begin
                r_cnt <= '0;
            end else if (o_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (o_cmd.load) begin
                r_in_ready <= 1'b0;
            end else if (o_cmd.publish) begin
                r_in_ready <= 1'b1;
            end
            if (o_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/extended_euclid_gcd_top.sv =====
// channel   dir  handshake                    tdata fields (lsb first)
// s_axis    in   s_axis_tvalid/s_axis_tready  operand_a, operand_b
// m_axis    out  m_axis_tvalid/m_axis_tready  gcd_value, coeff_s, coeff_t
//
// one item at a time; each quotient step is one check, one restoring-division bit
// per operand bit and one update, and each item adds a load, a final check and a
// publish; worst-case 31-bit operands take 45 quotient steps
// the divider is bit-serial and shared by all quotient steps
// synchronous active-low reset clears the controller only
// a result waits in the output register while the next item is accepted and computed
module extended_euclid_gcd_top #(
    parameter int DATA_WIDTH = eeg_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // operand_a, operand_b, zero pad
    input  logic [8*((2*DATA_WIDTH+5)/8)-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // gcd_value, coeff_s, coeff_t, zero pad
    output logic [8*((3*DATA_WIDTH+6)/8)-1:0]     m_axis_tdata
);

    localparam int OW     = DATA_WIDTH - 1;
    localparam int CW     = DATA_WIDTH;
    localparam int OUT_TW = 8 * ((OW + 2 * CW + 7) / 8);

    eeg_pkg::t_dp_cmd          w_cmd;
    eeg_pkg::t_dp_stat         w_stat;
    logic [OW-1:0]             w_gcd;
    logic signed [CW-1:0]      w_s;
    logic signed [CW-1:0]      w_t;

    // sequencer
    eeg_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // remainders, coefficients and divider
    eeg_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_operand_a (s_axis_tdata[OW-1:0]),
        .i_operand_b (s_axis_tdata[2*OW-1:OW]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_gcd_value (w_gcd),
        .o_coeff_s   (w_s),
        .o_coeff_t   (w_t)
    );

    // pack result item
    assign m_axis_tdata = OUT_TW'({w_t, w_s, w_gcd});

endmodule
